@@ src/wsp_pkg.sv @@
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int unsigned FrameBitsDefault = 32;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TickW = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef enum logic [2:0] {
    REG_SENSOR_ID,
    REG_CHANNEL,
    REG_PULSE_TICKS,
    REG_PREAMBLE_TICKS,
    REG_ONE_TICKS,
    REG_ZERO_TICKS,
    REG_REPETITIONS
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PULSE,
    PH_GAP
  } phase_e;

  localparam logic [7:0]       SensorIdReset      = 8'd0;
  localparam logic [1:0]       ChannelReset       = 2'd0;
  localparam logic [TickW-1:0] PulseTicksReset    = 16'd500;
  localparam logic [TickW-1:0] PreambleTicksReset = 16'd9000;
  localparam logic [TickW-1:0] OneTicksReset      = 16'd4000;
  localparam logic [TickW-1:0] ZeroTicksReset     = 16'd2000;
  localparam logic [7:0]       RepetitionsReset   = 8'd6;

  typedef struct packed {
    logic              operation;
    logic signed [11:0] temperature_tenths;
    logic              battery_good;
    logic              beep;
  } in_word_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic send_accepted;
    logic send_dropped;
  } out_word_t;

  typedef struct packed {
    logic [7:0]       sensor_id;
    logic [1:0]       channel;
    logic [TickW-1:0] pulse_ticks;
    logic [TickW-1:0] preamble_ticks;
    logic [TickW-1:0] one_ticks;
    logic [TickW-1:0] zero_ticks;
    logic [7:0]       repetitions;
  } cfg_t;

  // A length of zero behaves as a length of one.
  function automatic logic reached(logic [TickW-1:0] count, logic [TickW-1:0] len);
    logic [TickW-1:0] eff;
    eff = (len == '0) ? TickW'(1) : len;
    return count >= eff;
  endfunction

endpackage

@@ src/wsp_cfg_regs.sv @@
`timescale 1ns / 1ps

module wsp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wsp_pkg::CfgAddrW-1:0]   paddr,
  input  logic [wsp_pkg::CfgDataW-1:0]   pwdata,
  output logic [wsp_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output wsp_pkg::cfg_t                  cfg_o
);
  import wsp_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SENSOR_ID:      cfg_d.sensor_id      = pwdata[7:0];
        REG_CHANNEL:        cfg_d.channel        = pwdata[1:0];
        REG_PULSE_TICKS:    cfg_d.pulse_ticks    = pwdata[TickW-1:0];
        REG_PREAMBLE_TICKS: cfg_d.preamble_ticks = pwdata[TickW-1:0];
        REG_ONE_TICKS:      cfg_d.one_ticks      = pwdata[TickW-1:0];
        REG_ZERO_TICKS:     cfg_d.zero_ticks     = pwdata[TickW-1:0];
        REG_REPETITIONS:    cfg_d.repetitions    = pwdata[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SENSOR_ID:      prdata = CfgDataW'(cfg_q.sensor_id);
      REG_CHANNEL:        prdata = CfgDataW'(cfg_q.channel);
      REG_PULSE_TICKS:    prdata = CfgDataW'(cfg_q.pulse_ticks);
      REG_PREAMBLE_TICKS: prdata = CfgDataW'(cfg_q.preamble_ticks);
      REG_ONE_TICKS:      prdata = CfgDataW'(cfg_q.one_ticks);
      REG_ZERO_TICKS:     prdata = CfgDataW'(cfg_q.zero_ticks);
      REG_REPETITIONS:    prdata = CfgDataW'(cfg_q.repetitions);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_id      <= SensorIdReset;
      cfg_q.channel        <= ChannelReset;
      cfg_q.pulse_ticks    <= PulseTicksReset;
      cfg_q.preamble_ticks <= PreambleTicksReset;
      cfg_q.one_ticks      <= OneTicksReset;
      cfg_q.zero_ticks     <= ZeroTicksReset;
      cfg_q.repetitions    <= RepetitionsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/wsp_frame.sv @@
`timescale 1ns / 1ps

module wsp_frame #(
  parameter int unsigned FRAME_BITS = wsp_pkg::FrameBitsDefault
) (
  input  logic [7:0]            sensor_id_i,
  input  logic [1:0]            channel_i,
  input  logic signed [11:0]    temperature_tenths_i,
  input  logic                  battery_good_i,
  input  logic                  beep_i,
  output logic [FRAME_BITS-1:0] frame_o
);
  import wsp_pkg::*;

  logic [23:0] body;
  logic [7:0]  csum;
  logic [31:0] full;

  assign body = {sensor_id_i, $unsigned(temperature_tenths_i), channel_i,
                 !battery_good_i, beep_i};

  // Sum of the low bytes of the body shifted by each multiple of four bits, less one.
  always_comb begin
    logic [31:0] wide;
    logic [7:0]  acc;
    wide = {8'd0, body};
    acc  = 8'd0;
    for (int k = 0; k < 7; k++) begin
      acc = acc + wide[4*k +: 8];
    end
    csum = acc - 8'd1;
  end

  assign full    = {csum, body};
  assign frame_o = full[FRAME_BITS-1:0];

endmodule

@@ src/wsp_encoder.sv @@
`timescale 1ns / 1ps

module wsp_encoder #(
  parameter int unsigned FRAME_BITS = wsp_pkg::FrameBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wsp_pkg::cfg_t         cfg_i,
  input  wsp_pkg::in_word_t     item_i,
  input  logic [FRAME_BITS-1:0] frame_i,
  input  logic                  load_i,
  output wsp_pkg::out_word_t    result_o
);
  import wsp_pkg::*;

  localparam int unsigned IdxW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BITS - 1);

  phase_e                phase_q, phase_d;
  logic [TickW-1:0]      tick_q, tick_d;
  logic [IdxW-1:0]       bit_q, bit_d;
  logic [7:0]            packets_q, packets_d;
  logic                  pre_q, pre_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  out_word_t             result_q, result_d;

  logic [TickW-1:0] tick_inc;
  logic [TickW-1:0] gap_len;
  logic             accepted;
  logic             dropped;

  assign tick_inc = tick_q + TickW'(1);
  assign gap_len  = pre_q ? cfg_i.preamble_ticks :
                    (frame_q[bit_q] ? cfg_i.one_ticks : cfg_i.zero_ticks);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    packets_d = packets_q;
    pre_d     = pre_q;
    frame_d   = frame_q;
    accepted  = 1'b0;
    dropped   = 1'b0;
    if (item_i.operation == OP_SEND) begin
      if (phase_q != PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        accepted  = 1'b1;
        frame_d   = frame_i;
        packets_d = cfg_i.repetitions;
        if (cfg_i.repetitions != 8'd0) begin
          phase_d = PH_PULSE;
          pre_d   = 1'b1;
          tick_d  = '0;
          bit_d   = '0;
        end
      end
    end else if (phase_q == PH_PULSE) begin
      tick_d = tick_inc;
      if (reached(tick_inc, cfg_i.pulse_ticks)) begin
        phase_d = PH_GAP;
        tick_d  = '0;
      end
    end else if (phase_q == PH_GAP) begin
      tick_d = tick_inc;
      if (reached(tick_inc, gap_len)) begin
        tick_d = '0;
        if (pre_q) begin
          pre_d   = 1'b0;
          bit_d   = LastIdx;
          phase_d = PH_PULSE;
        end else if (bit_q != '0) begin
          bit_d   = bit_q - IdxW'(1);
          phase_d = PH_PULSE;
        end else begin
          packets_d = packets_q - 8'd1;
          if (packets_d != 8'd0) begin
            phase_d = PH_PULSE;
            pre_d   = 1'b1;
            bit_d   = '0;
          end else begin
            phase_d = PH_IDLE;
            pre_d   = 1'b0;
          end
        end
      end
    end
    result_d.line_level    = (phase_d == PH_PULSE);
    result_d.busy_res      = (phase_d != PH_IDLE);
    result_d.send_accepted = accepted;
    result_d.send_dropped  = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      packets_q <= '0;
      pre_q     <= 1'b0;
    end else if (load_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      packets_q <= packets_d;
      pre_q     <= pre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q  <= frame_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

@@ src/weather_sensor_pulse_transmitter.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// in        in_valid_i / in_ready_o      in_data_i  (operation, temperature, battery, beep)
// out       out_valid_o / out_ready_i    out_data_o (line level, busy, accepted, dropped)
// cfg       psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// Each word is held in the input register and is then processed into the result register,
// so a new word is taken in every cycle while the result is not stalled.
// Reset clears the configuration to its defaults and leaves the transmitter idle.
// A stalled result holds the result register and, behind it, the input register.

module weather_sensor_pulse_transmitter #(
  parameter int unsigned FRAME_BITS = wsp_pkg::FrameBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wsp_pkg::in_word_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wsp_pkg::out_word_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsp_pkg::CfgAddrW-1:0] paddr,
  input  logic [wsp_pkg::CfgDataW-1:0] pwdata,
  output logic [wsp_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import wsp_pkg::*;

  cfg_t                  cfg;
  in_word_t              item_q;
  logic                  item_valid_q;
  logic                  out_valid_q;
  logic                  advance;
  logic                  load;
  logic [FRAME_BITS-1:0] frame;

  assign advance    = !out_valid_q || out_ready_i;
  assign load       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  wsp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wsp_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .sensor_id_i          (cfg.sensor_id),
    .channel_i            (cfg.channel),
    .temperature_tenths_i (item_q.temperature_tenths),
    .battery_good_i       (item_q.battery_good),
    .beep_i               (item_q.beep),
    .frame_o              (frame)
  );

  wsp_encoder #(
    .FRAME_BITS (FRAME_BITS)
  ) u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .frame_i  (frame),
    .load_i   (load),
    .result_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.line_level) |-> out_data_o.busy_res)
    else $error("line high while not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.send_dropped) |->
      (out_data_o.busy_res && !out_data_o.send_accepted))
    else $error("dropped send reported while idle or as accepted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");
`endif

endmodule
